### sv/mrs_pkg.sv
`default_nettype none

package mrs_pkg;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_DAY    = 3'd0,
      REG_FIXED_TIME    = 3'd1,
      REG_TARGET_HOUR   = 3'd2,
      REG_TARGET_MINUTE = 3'd3,
      REG_TARGET_SECOND = 3'd4
   } csr_index_type;

   // Field widths.
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;

   // Internal year carries the wrap to -1 and 4096, so it is signed and wider.
   localparam int unsigned YEAR_EXT_W = 14;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;

   // Calendar constants.
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAY_DEFAULT = 5'd1;

   localparam logic signed [YEAR_EXT_W-1:0] YEAR_MIN = 14'sd1970;
   localparam logic signed [YEAR_EXT_W-1:0] YEAR_MAX = 14'sd2105;

   // n / 100 as (n * 5243) >> 19, exact for n below 43699.
   localparam int unsigned DIV100_W     = 13;
   localparam logic [DIV100_W-1:0] DIV100_MUL = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;
   localparam int unsigned QUOT_W       = 7;

   typedef struct packed {
      logic [DAY_W-1:0]    target_day;
      logic                fixed_time;
      logic [HOUR_W-1:0]   target_hour;
      logic [MINUTE_W-1:0] target_minute;
      logic [SECOND_W-1:0] target_second;
   } cfg_type;

   typedef struct packed {
      logic                opcode;
      logic [YEAR_W-1:0]   in_year;
      logic [MONTH_W-1:0]  in_month;
      logic [DAY_W-1:0]    in_day;
      logic [HOUR_W-1:0]   in_hour;
      logic [MINUTE_W-1:0] in_minute;
      logic [SECOND_W-1:0] in_second;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   out_year;
      logic [MONTH_W-1:0]  out_month;
      logic [DAY_W-1:0]    out_day;
      logic [HOUR_W-1:0]   out_hour;
      logic [MINUTE_W-1:0] out_minute;
      logic [SECOND_W-1:0] out_second;
      logic                year_out_of_range;
   } rsp_type;

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

`default_nettype wire

### sv/mrs_datapath.sv
`default_nettype none

module mrs_datapath
   import mrs_pkg::*;
(
   input  wire logic         clock,
   input  wire stage_en_type en,
   input  wire cfg_type      cfg,
   input  wire req_type      req,
   output rsp_type           rsp
);

   typedef struct packed {
      logic signed [YEAR_EXT_W-1:0] year;
      logic [MONTH_W-1:0]           month;
   } ym_type;

   // One month forward or back, wrapping the year.
   function automatic ym_type step_month(input ym_type cur, input logic back);
      ym_type res;
      res = cur;
      if (back) begin
         if (cur.month > MONTH_JAN) begin
            res.month = cur.month - 4'd1;
         end else begin
            res.month = MONTH_DEC;
            res.year  = cur.year - 14'sd1;
         end
      end else begin
         if (cur.month < MONTH_DEC) begin
            res.month = cur.month + 4'd1;
         end else begin
            res.month = MONTH_JAN;
            res.year  = cur.year + 14'sd1;
         end
      end
      return res;
   endfunction

   // Fields that ride unchanged through the pipeline.
   typedef struct packed {
      logic                back;
      logic [DAY_W-1:0]    tday;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } carry_type;

   // Stage 1: clamp month, pick time of day, decide the first month step.
   carry_type         c1_ff, c1_in;
   logic [YEAR_W-1:0] year1_ff;
   logic [MONTH_W-1:0] month1_ff, month1_in;
   logic              step1_ff, step1_in;

   logic [HOUR_W+MINUTE_W+SECOND_W-1:0] tin;
   logic [HOUR_W+MINUTE_W+SECOND_W-1:0] tcand;

   always_comb begin
      c1_in.back = req.opcode;
      c1_in.tday = (cfg.target_day == '0) ? DAY_DEFAULT : cfg.target_day;
      if (cfg.fixed_time) begin
         c1_in.hour   = cfg.target_hour;
         c1_in.minute = cfg.target_minute;
         c1_in.second = cfg.target_second;
      end else begin
         c1_in.hour   = req.in_hour;
         c1_in.minute = req.in_minute;
         c1_in.second = req.in_second;
      end

      month1_in = req.in_month;
      if (req.in_month == '0) begin
         month1_in = MONTH_JAN;
      end else if (req.in_month > MONTH_DEC) begin
         month1_in = MONTH_DEC;
      end

      tin   = {req.in_hour, req.in_minute, req.in_second};
      tcand = {c1_in.hour, c1_in.minute, c1_in.second};

      // On the target day the candidate must lie strictly beyond the reference.
      if (c1_in.tday == req.in_day) begin
         step1_in = req.opcode ? (tcand >= tin) : (tcand <= tin);
      end else if (c1_in.tday > req.in_day) begin
         step1_in = req.opcode;
      end else begin
         step1_in = !req.opcode;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         c1_ff     <= c1_in;
         year1_ff  <= req.in_year;
         month1_ff <= month1_in;
         step1_ff  <= step1_in;
      end
   end

   // Stage 2: apply the first month step.
   carry_type c2_ff;
   ym_type    ym2_ff, ym2_in, ym1;

   always_comb begin
      ym1.year  = $signed({2'b00, year1_ff});
      ym1.month = month1_ff;
      ym2_in    = step1_ff ? step_month(ym1, c1_ff.back) : ym1;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         c2_ff  <= c1_ff;
         ym2_ff <= ym2_in;
      end
   end

   // Stage 3: year / 100 by reciprocal multiplication for the century test.
   carry_type               c3_ff;
   ym_type                  ym3_ff;
   logic [QUOT_W-1:0]       quot3_ff, quot3_in;
   logic [2*DIV100_W-1:0]   prod;

   always_comb begin
      prod     = ym2_ff.year[DIV100_W-1:0] * DIV100_MUL;
      quot3_in = prod[DIV100_SHIFT +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         c3_ff    <= c2_ff;
         ym3_ff   <= ym2_ff;
         quot3_ff <= quot3_in;
      end
   end

   // Stage 4: month length, skip a month lacking the target day, range flag.
   rsp_type rsp_ff, rsp_in;

   logic                    leap;
   logic                    century;
   logic [YEAR_EXT_W-1:0]   hundreds;
   logic [DAY_W-1:0]        mlen;
   ym_type                  ym4;

   always_comb begin
      // The only negative year, -1, has low bits 11 and so never tests as leap.
      hundreds = YEAR_EXT_W'(quot3_ff) * 14'd100;
      century  = ({1'b0, ym3_ff.year[YEAR_EXT_W-2:0]} == hundreds);
      leap     = (ym3_ff.year[1:0] == 2'b00) && (!century || (quot3_ff[1:0] == 2'b00));

      if (ym3_ff.month == MONTH_FEB) begin
         mlen = leap ? 5'd29 : 5'd28;
      end else if ((ym3_ff.month == MONTH_APR) || (ym3_ff.month == MONTH_JUN) ||
                   (ym3_ff.month == MONTH_SEP) || (ym3_ff.month == MONTH_NOV)) begin
         mlen = 5'd30;
      end else begin
         mlen = 5'd31;
      end

      // A short month is always followed and preceded by a 31-day month.
      ym4 = (c3_ff.tday > mlen) ? step_month(ym3_ff, c3_ff.back) : ym3_ff;

      rsp_in.out_year          = ym4.year[YEAR_W-1:0];
      rsp_in.out_month         = ym4.month;
      rsp_in.out_day           = c3_ff.tday;
      rsp_in.out_hour          = c3_ff.hour;
      rsp_in.out_minute        = c3_ff.minute;
      rsp_in.out_second        = c3_ff.second;
      rsp_in.year_out_of_range = (ym4.year < YEAR_MIN) || (ym4.year > YEAR_MAX);
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

### sv/monthly_recurrence_step_unit.sv
// A request transaction passes stage registers s1, s2, s3, s4 in order, and
// rsp_tvalid is s4's valid bit. Throughput: one transaction per cycle unless
// all four stages are full and rsp_tready is low; each stage holds an item,
// and an empty stage is filled even while the response stage is stalled.
// Reset (synchronous, active high) empties the pipeline and sets target_day
// to 1 and fixed_time, target_hour, target_minute and target_second to 0.
`default_nettype none

module monthly_recurrence_step_unit
   import mrs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // in_year, in_month, in_day, in_hour, in_minute, in_second, zero pad
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  wire logic                   req_tuser,

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_year, out_month, out_day, out_hour, out_minute, out_second, zero pad
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // year_out_of_range
   output logic                        rsp_tuser,

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TARGET_DAY:    cfg_in.target_day    = csr_wdata[DAY_W-1:0];
            REG_FIXED_TIME:    cfg_in.fixed_time    = csr_wdata[0];
            REG_TARGET_HOUR:   cfg_in.target_hour   = csr_wdata[HOUR_W-1:0];
            REG_TARGET_MINUTE: cfg_in.target_minute = csr_wdata[MINUTE_W-1:0];
            REG_TARGET_SECOND: cfg_in.target_second = csr_wdata[SECOND_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_day    <= DAY_DEFAULT;
         cfg_ff.fixed_time    <= 1'b0;
         cfg_ff.target_hour   <= '0;
         cfg_ff.target_minute <= '0;
         cfg_ff.target_second <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline valid bits; a stage loads when it is empty or its item moves on.
   logic [3:0]   valid_ff, valid_in;
   stage_en_type en;

   always_comb begin
      en.s4 = !valid_ff[3] || rsp_tready;
      en.s3 = !valid_ff[2] || en.s4;
      en.s2 = !valid_ff[1] || en.s3;
      en.s1 = !valid_ff[0] || en.s2;

      valid_in[0] = en.s1 ? req_tvalid  : valid_ff[0];
      valid_in[1] = en.s2 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en.s3 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en.s4 ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en.s1;
   assign rsp_tvalid = valid_ff[3];

   // Unpack the request transaction.
   req_type req;

   always_comb begin
      req.opcode    = req_tuser;
      req.in_year   = req_tdata[11:0];
      req.in_month  = req_tdata[15:12];
      req.in_day    = req_tdata[20:16];
      req.in_hour   = req_tdata[25:21];
      req.in_minute = req_tdata[31:26];
      req.in_second = req_tdata[37:32];
   end

   rsp_type rsp;

   mrs_datapath u_datapath (
      .clock (clock),
      .en    (en),
      .cfg   (cfg_ff),
      .req   (req),
      .rsp   (rsp)
   );

   // Pack the response transaction.
   assign rsp_tdata = {2'b00, rsp.out_second, rsp.out_minute, rsp.out_hour,
                       rsp.out_day, rsp.out_month, rsp.out_year};
   assign rsp_tuser = rsp.year_out_of_range;

endmodule

`default_nettype wire

### tb/mrs_occurrence_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the monthly recurrence
// unit, predicts each occurrence from a private copy of the registers, and
// compares every response transaction with the oldest prediction.
module mrs_occurrence_checker
   import mrs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   rsp_tuser,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatches,
   output int                          outstanding
);

   // Bit offsets of the packed date-time fields, year in the lowest bits.
   localparam int unsigned OFS_MONTH  = YEAR_W;
   localparam int unsigned OFS_DAY    = OFS_MONTH + MONTH_W;
   localparam int unsigned OFS_HOUR   = OFS_DAY + DAY_W;
   localparam int unsigned OFS_MINUTE = OFS_HOUR + HOUR_W;
   localparam int unsigned OFS_SECOND = OFS_MINUTE + MINUTE_W;

   localparam cfg_type CFG_AT_RESET = '{
      target_day: DAY_DEFAULT, fixed_time: 1'b0,
      target_hour: '0, target_minute: '0, target_second: '0};

   cfg_type live_cfg = CFG_AT_RESET;
   rsp_type awaited_occurrences[$];

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   // Gregorian leap rule; year -1 is folded onto 399.
   function automatic bit leap_year(input int yr);
      int u;
      u = (yr < 0) ? yr + 400 : yr;
      return (u % 4 == 0) && ((u % 100 != 0) || (u % 400 == 0));
   endfunction

   function automatic int days_in_month(input int yr, input int mon);
      if (mon == MONTH_FEB) return leap_year(yr) ? 29 : 28;
      if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP || mon == MONTH_NOV)
         return 30;
      return 31;
   endfunction

   // Nearest occurrence of the configured day in the requested direction.
   function automatic rsp_type find_occurrence(input req_type q, input cfg_type c);
      rsp_type             r;
      int                  yr;
      int                  mon;
      int                  mcount;
      int                  day_goal;
      int                  i;
      bit                  step;
      logic [HOUR_W-1:0]   hh;
      logic [MINUTE_W-1:0] mm;
      logic [SECOND_W-1:0] ss;
      logic [16:0]         t_ref;
      logic [16:0]         t_hit;

      yr = int'(q.in_year);
      mon = int'(q.in_month);
      if (mon == 0) mon = int'(MONTH_JAN);
      if (mon > int'(MONTH_DEC)) mon = int'(MONTH_DEC);
      day_goal = (c.target_day == '0) ? int'(DAY_DEFAULT) : int'(c.target_day);

      hh = c.fixed_time ? c.target_hour : q.in_hour;
      mm = c.fixed_time ? c.target_minute : q.in_minute;
      ss = c.fixed_time ? c.target_second : q.in_second;
      t_ref = {q.in_hour, q.in_minute, q.in_second};
      t_hit = {hh, mm, ss};

      // On the target day the candidate must lie strictly beyond the reference.
      if (day_goal == q.in_day)
         step = q.opcode ? (t_hit >= t_ref) : (t_hit <= t_ref);
      else if (day_goal > q.in_day)
         step = q.opcode;
      else
         step = !q.opcode;

      // Months are counted linearly from January of year -1 so that stepping
      // across a year boundary is a plus or minus one.
      mcount = (yr + 1) * 12 + mon - 1;
      if (step) mcount += q.opcode ? -1 : 1;
      yr = mcount / 12 - 1;
      mon = mcount % 12 + 1;

      // Skip months that are too short for the target day.
      for (i = 0; i < 12 && day_goal > days_in_month(yr, mon); i++) begin
         mcount += q.opcode ? -1 : 1;
         yr = mcount / 12 - 1;
         mon = mcount % 12 + 1;
      end

      r.out_year = yr[YEAR_W-1:0];
      r.out_month = mon[MONTH_W-1:0];
      r.out_day = day_goal[DAY_W-1:0];
      r.out_hour = hh;
      r.out_minute = mm;
      r.out_second = ss;
      r.year_out_of_range = (yr < YEAR_MIN) || (yr > YEAR_MAX);
      return r;
   endfunction

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // Predict on each request transaction, compare on each response transaction.
   always @(posedge clock) begin : monitor
      req_type q;
      rsp_type want;
      rsp_type got;

      if (reset) begin
         live_cfg <= CFG_AT_RESET;
         awaited_occurrences.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_year = rsp_tdata[0 +: YEAR_W];
            got.out_month = rsp_tdata[OFS_MONTH +: MONTH_W];
            got.out_day = rsp_tdata[OFS_DAY +: DAY_W];
            got.out_hour = rsp_tdata[OFS_HOUR +: HOUR_W];
            got.out_minute = rsp_tdata[OFS_MINUTE +: MINUTE_W];
            got.out_second = rsp_tdata[OFS_SECOND +: SECOND_W];
            got.year_out_of_range = rsp_tuser;
            if (awaited_occurrences.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = awaited_occurrences.pop_front();
               compare_field("out_year", int'(want.out_year), int'(got.out_year));
               compare_field("out_month", int'(want.out_month), int'(got.out_month));
               compare_field("out_day", int'(want.out_day), int'(got.out_day));
               compare_field("out_hour", int'(want.out_hour), int'(got.out_hour));
               compare_field("out_minute", int'(want.out_minute), int'(got.out_minute));
               compare_field("out_second", int'(want.out_second), int'(got.out_second));
               compare_field("year_out_of_range", int'(want.year_out_of_range),
                             int'(got.year_out_of_range));
            end
         end

         if (req_tvalid && req_tready) begin
            q.opcode = req_tuser;
            q.in_year = req_tdata[0 +: YEAR_W];
            q.in_month = req_tdata[OFS_MONTH +: MONTH_W];
            q.in_day = req_tdata[OFS_DAY +: DAY_W];
            q.in_hour = req_tdata[OFS_HOUR +: HOUR_W];
            q.in_minute = req_tdata[OFS_MINUTE +: MINUTE_W];
            q.in_second = req_tdata[OFS_SECOND +: SECOND_W];
            awaited_occurrences.push_back(find_occurrence(q, live_cfg));
         end

         // Register writes take effect for transactions after this edge.
         if (csr_we) begin
            case (csr_index)
               REG_TARGET_DAY: begin
                  live_cfg.target_day <= csr_wdata[DAY_W-1:0];
               end
               REG_FIXED_TIME: begin
                  live_cfg.fixed_time <= csr_wdata[0];
               end
               REG_TARGET_HOUR: begin
                  live_cfg.target_hour <= csr_wdata[HOUR_W-1:0];
               end
               REG_TARGET_MINUTE: begin
                  live_cfg.target_minute <= csr_wdata[MINUTE_W-1:0];
               end
               REG_TARGET_SECOND: begin
                  live_cfg.target_second <= csr_wdata[SECOND_W-1:0];
               end
               default: begin
               end
            endcase
         end

         outstanding <= awaited_occurrences.size();
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import mrs_pkg::*;

   localparam int PIPE_LATENCY = 4;
   localparam int STALL_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 67;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // in_year, in_month, in_day, in_hour, in_minute, in_second, zero pad
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // opcode
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // out_year, out_month, out_day, out_hour, out_minute, out_second, zero pad
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // year_out_of_range
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int      mismatches;
   int      outstanding;
   int      send_idle_pct = 37;
   int      recv_idle_pct = 48;
   int      hold_asked = 0;
   int      hold_given = 0;
   int      hold_left = 0;
   int      stall_cycles = 0;
   logic    req_taken = 1'b0;
   cfg_type cur_cfg;

   monthly_recurrence_step_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mrs_occurrence_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Acceptance at the last rising edge, read by the sender at the falling edge.
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
   end

   // Receiver: random back-pressure, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         hold_given <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("monthly_recurrence_step_unit regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type query(input logic op, input int yr, input int mo,
                                     input int dy, input int hr, input int mi,
                                     input int se);
      req_type q;
      q.opcode = op;
      q.in_year = yr[YEAR_W-1:0];
      q.in_month = mo[MONTH_W-1:0];
      q.in_day = dy[DAY_W-1:0];
      q.in_hour = hr[HOUR_W-1:0];
      q.in_minute = mi[MINUTE_W-1:0];
      q.in_second = se[SECOND_W-1:0];
      return q;
   endfunction

   function automatic cfg_type settings(input int dy, input logic strict, input int hr,
                                        input int mi, input int se);
      cfg_type c;
      c.target_day = dy[DAY_W-1:0];
      c.fixed_time = strict;
      c.target_hour = hr[HOUR_W-1:0];
      c.target_minute = mi[MINUTE_W-1:0];
      c.target_second = se[SECOND_W-1:0];
      return c;
   endfunction

   // Mostly legal register values, leaning on the short-month days.
   function automatic cfg_type random_settings();
      cfg_type c;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 10) c.target_day = '0;
      else if (pick < 45) c.target_day = DAY_W'($urandom_range(31, 28));
      else c.target_day = DAY_W'($urandom_range(31, 1));
      c.fixed_time = 1'($urandom_range(1));
      c.target_hour = HOUR_W'(($urandom_range(9) != 0) ? $urandom_range(23)
                                                        : $urandom_range(31));
      c.target_minute = MINUTE_W'(($urandom_range(9) != 0) ? $urandom_range(59)
                                                            : $urandom_range(63));
      c.target_second = SECOND_W'(($urandom_range(9) != 0) ? $urandom_range(59)
                                                            : $urandom_range(63));
      return c;
   endfunction

   // Random reference date-time, biased toward the target day and legal ranges.
   function automatic req_type random_query();
      req_type q;
      int      pick;
      int      goal;

      q.opcode = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 70) begin
         q.in_year = YEAR_W'($urandom_range(2105, 1970));
      end else if (pick < 85) begin
         case ($urandom_range(7))
            0: q.in_year = 12'd0;
            1: q.in_year = 12'd1;
            2: q.in_year = 12'd1969;
            3: q.in_year = 12'd1970;
            4: q.in_year = 12'd2105;
            5: q.in_year = 12'd2106;
            6: q.in_year = 12'd4094;
            default: q.in_year = 12'd4095;
         endcase
      end else begin
         q.in_year = YEAR_W'($urandom_range(4095));
      end
      q.in_month = MONTH_W'(($urandom_range(9) != 0) ? $urandom_range(12, 1)
                                                      : $urandom_range(15));

      goal = (cur_cfg.target_day == '0) ? int'(DAY_DEFAULT) : int'(cur_cfg.target_day);
      pick = $urandom_range(99);
      if (pick < 40) q.in_day = DAY_W'(goal);
      else if (pick < 90) q.in_day = DAY_W'($urandom_range(31, 1));
      else q.in_day = DAY_W'($urandom_range(31));

      if ($urandom_range(99) < 85) begin
         q.in_hour = HOUR_W'($urandom_range(23));
         q.in_minute = MINUTE_W'($urandom_range(59));
         q.in_second = SECOND_W'($urandom_range(59));
      end else begin
         q.in_hour = HOUR_W'($urandom_range(31));
         q.in_minute = MINUTE_W'($urandom_range(63));
         q.in_second = SECOND_W'($urandom_range(63));
      end

      // On the target day, land on or right next to the configured time.
      if (q.in_day == goal && cur_cfg.fixed_time && $urandom_range(3) == 0) begin
         q.in_hour = cur_cfg.target_hour;
         q.in_minute = cur_cfg.target_minute;
         q.in_second = cur_cfg.target_second;
         case ($urandom_range(2))
            1: q.in_second = q.in_second + 6'd1;
            2: q.in_second = q.in_second - 6'd1;
            default: begin
            end
         endcase
      end
      return q;
   endfunction

   // Offers one request transaction and returns at the falling edge after it is taken.
   task automatic put_query(input req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.opcode;
      req_tdata <= {2'b00, q.in_second, q.in_minute, q.in_hour, q.in_day, q.in_month,
                    q.in_year};
      do begin
         @(negedge clock);
      end while (!req_taken);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Registers change only once the pipeline has drained.
   task automatic apply_config(input cfg_type c);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
      write_register(REG_TARGET_DAY, CSR_DATA_W'(c.target_day));
      write_register(REG_FIXED_TIME, CSR_DATA_W'(c.fixed_time));
      write_register(REG_TARGET_HOUR, CSR_DATA_W'(c.target_hour));
      write_register(REG_TARGET_MINUTE, CSR_DATA_W'(c.target_minute));
      write_register(REG_TARGET_SECOND, CSR_DATA_W'(c.target_second));
      csr_we <= 1'b0;
      cur_cfg = c;
   endtask

   initial begin
      cur_cfg = settings(int'(DAY_DEFAULT), 1'b0, 0, 0, 0);
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset registers: year wrap at both ends, month and day fields out of range.
      put_query(query(1'b1, 0, 1, 1, 0, 0, 0));
      put_query(query(1'b0, 4095, 12, 1, 0, 0, 0));
      put_query(query(1'b0, 2024, 0, 0, 0, 0, 0));
      put_query(query(1'b1, 2024, 15, 0, 31, 63, 63));
      put_query(query(1'b0, 2105, 12, 31, 23, 59, 59));
      put_query(query(1'b1, 1970, 1, 5, 12, 30, 30));

      // Day 31 with fixed time: short months are skipped in both directions.
      apply_config(settings(31, 1'b1, 23, 59, 59));
      put_query(query(1'b0, 2023, 4, 31, 12, 0, 0));
      put_query(query(1'b1, 2023, 4, 30, 0, 0, 0));
      put_query(query(1'b0, 2023, 1, 31, 23, 59, 59));
      put_query(query(1'b1, 2023, 3, 31, 23, 59, 59));
      put_query(query(1'b0, 2023, 1, 31, 31, 0, 0));
      put_query(query(1'b1, 4095, 13, 31, 0, 0, 0));

      // Day 29 with input time kept: century leap years.
      apply_config(settings(29, 1'b0, 0, 0, 0));
      put_query(query(1'b0, 1900, 2, 1, 0, 0, 0));
      put_query(query(1'b0, 2000, 2, 1, 0, 0, 0));
      put_query(query(1'b1, 2100, 3, 1, 0, 0, 0));
      put_query(query(1'b0, 2104, 2, 29, 10, 0, 0));
      put_query(query(1'b1, 0, 3, 1, 0, 0, 0));

      // Target day zero behaves as day one; register time fields at full width.
      apply_config(settings(0, 1'b1, 31, 63, 63));
      put_query(query(1'b0, 2050, 6, 1, 0, 0, 0));
      put_query(query(1'b1, 2050, 6, 1, 31, 63, 63));
      put_query(query(1'b0, 2050, 6, 0, 5, 5, 5));
      put_query(query(1'b1, 2050, 1, 2, 5, 5, 5));

      // Random phases: receiver idles more, then sender idles more, then no idling
      // with one long receiver hold-off while the sender keeps offering.
      for (int phase = 0; phase < 6; phase++) begin
         apply_config(random_settings());
         if (phase < 2) begin
            send_idle_pct = 37;
            recv_idle_pct = 48;
         end else if (phase < 4) begin
            send_idle_pct = 48;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 4) hold_asked++;
         repeat (PHASE_ITEMS) put_query(random_query());
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (PIPE_LATENCY * 2) @(posedge clock);
      if (mismatches == 0) begin
         $display("monthly_recurrence_step_unit regression: pass");
      end else begin
         $display("monthly_recurrence_step_unit regression: fail");
      end
      $finish;
   end

endmodule
